### sv/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMEM    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam logic REG_HEAP_LIMIT   = 1'b0;
  localparam logic REG_HEADER_BYTES = 1'b1;

  localparam int unsigned ALIGN = 8;
  localparam int unsigned HDR_MIN = 8;
  localparam int unsigned HDR_MAX = 64;

  typedef struct packed {
    logic [31:0] start;
    logic [32:0] length;
    logic        is_free;
  } chunk_t;

  // Rounded length, 33 bits so huge requests cannot wrap.
  function automatic logic [32:0] round_size(input logic [31:0] req);
    logic [32:0] r;
    r = ({1'b0, req} + 33'd7) & ~33'd7;
    if (r < 33'd8) r = 33'd8;
    return r;
  endfunction

endpackage

### sv/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a chunk table held in one synchronous memory.
// ----------------------------------------------------------------------------
// Each scan covers at most chunk_count entries; every entry is read in a read
// state and then checked in a check state.
// A resize that moves the chunk scans twice and writes twice.
// Throughput: one request at a time; the next is taken once the response leaves.
// Reset clears the chunk count and break and sets the heap limit and header size to defaults; table contents need none.
module first_fit_heap_allocator #(
  parameter int MAX_CHUNKS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // op[1:0], req_size[33:2], address[65:34], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // result_address[31:0], status[33:32], copy_bytes[65:34]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int CW = $clog2(MAX_CHUNKS + 1);

  typedef enum logic [3:0] {
    IDLE, FIND_RD, FIND_CHK, ALLOC_RD, ALLOC_CHK, APPEND, FREE_OLD, DONE
  } state_t;

  state_t state;
  ffha_pkg::chunk_t mem [MAX_CHUNKS];
  ffha_pkg::chunk_t rd;
  logic [IW-1:0] raddr, waddr;
  logic          we;
  ffha_pkg::chunk_t wdata;

  logic [31:0] heap_limit;
  logic [6:0]  header_bytes;
  logic [CW-1:0] chunk_count;
  logic [32:0] break_offset;

  logic [1:0]  op;
  logic [31:0] addr;
  logic [32:0] len;
  logic [CW-1:0] idx;
  logic [IW-1:0] old_idx;
  logic [32:0] old_len;
  logic        resize_move;
  logic [31:0] res_addr, copy;
  logic [1:0]  status;
  logic [6:0]  hdr;
  logic [33:0] new_break;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  always_comb begin
    if (header_bytes < 7'(ffha_pkg::HDR_MIN)) hdr = 7'(ffha_pkg::HDR_MIN);
    else if (header_bytes > 7'(ffha_pkg::HDR_MAX)) hdr = 7'(ffha_pkg::HDR_MAX);
    else hdr = header_bytes;
    new_break = {1'b0, break_offset} + 34'(hdr) + {1'b0, len};
  end

  assign raddr = idx[IW-1:0];
  assign s_tready = (state == IDLE) && !m_tvalid;
  assign m_tdata = {6'd0, copy, status, res_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      we <= 1'b0;
      m_tvalid <= 1'b0;
      heap_limit <= 32'd1048576;
      header_bytes <= 7'd24;
      chunk_count <= '0;
      break_offset <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ffha_pkg::REG_HEAP_LIMIT:   heap_limit <= cfg_data;
          ffha_pkg::REG_HEADER_BYTES: header_bytes <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (state == DONE) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        IDLE: begin
          we <= 1'b0;
          if (s_tvalid && s_tready) begin
            op <= s_tdata[1:0];
            len <= ffha_pkg::round_size(s_tdata[33:2]);
            addr <= s_tdata[65:34];
            res_addr <= '0;
            copy <= '0;
            status <= ffha_pkg::ST_OK;
            resize_move <= 1'b0;
            idx <= '0;
            if (s_tdata[1:0] == ffha_pkg::OP_ALLOC ||
                (s_tdata[1:0] == ffha_pkg::OP_RESIZE && s_tdata[65:34] == 32'd0))
              state <= ALLOC_RD;
            else if ((s_tdata[1:0] == ffha_pkg::OP_FREE ||
                      s_tdata[1:0] == ffha_pkg::OP_RESIZE) && s_tdata[65:34] != 32'd0)
              state <= FIND_RD;
            else
              state <= DONE;
          end
        end
        FIND_RD: begin
          we <= 1'b0;
          if (idx >= chunk_count) begin
            status <= ffha_pkg::ST_NOTFOUND;
            state <= DONE;
          end else state <= FIND_CHK;
        end
        FIND_CHK: begin
          we <= (rd.start == addr) && (op == ffha_pkg::OP_FREE);
          if (rd.start == addr) begin
            old_idx <= idx[IW-1:0];
            old_len <= rd.length;
            if (op == ffha_pkg::OP_FREE) begin
              waddr <= idx[IW-1:0];
              wdata <= '{start: rd.start, length: rd.length, is_free: 1'b1};
              state <= DONE;
            end else if (rd.length >= len) begin
              res_addr <= addr;
              state <= DONE;
            end else begin
              resize_move <= 1'b1;
              idx <= '0;
              state <= ALLOC_RD;
            end
          end else begin
            idx <= idx + 1'b1;
            state <= FIND_RD;
          end
        end
        ALLOC_RD: begin
          we <= 1'b0;
          if (idx >= chunk_count) state <= APPEND;
          else state <= ALLOC_CHK;
        end
        ALLOC_CHK: begin
          we <= rd.is_free && rd.length >= len;
          if (rd.is_free && rd.length >= len) begin
            waddr <= idx[IW-1:0];
            wdata <= '{start: rd.start, length: rd.length, is_free: 1'b0};
            res_addr <= rd.start;
            state <= resize_move ? FREE_OLD : DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= ALLOC_RD;
          end
        end
        APPEND: begin
          if (chunk_count >= CW'(MAX_CHUNKS) || new_break > {2'b0, heap_limit}) begin
            we <= 1'b0;
            status <= ffha_pkg::ST_NOMEM;
            state <= DONE;
          end else begin
            we <= 1'b1; waddr <= chunk_count[IW-1:0];
            wdata <= '{start: 32'(break_offset + 33'(hdr)), length: len, is_free: 1'b0};
            res_addr <= 32'(break_offset + 33'(hdr));
            chunk_count <= chunk_count + 1'b1;
            break_offset <= new_break[32:0];
            state <= resize_move ? FREE_OLD : DONE;
          end
        end
        FREE_OLD: begin
          we <= 1'b1; waddr <= old_idx;
          wdata <= '{start: addr, length: old_len, is_free: 1'b1};
          copy <= old_len[31:0];
          state <= DONE;
        end
        DONE: begin
          we <= 1'b0;
          state <= IDLE;
        end
        default: begin
          we <= 1'b0;
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == IDLE) else $error("ready outside idle");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    chunk_count <= CW'(MAX_CHUNKS)) else $error("chunk count overflow");
  a_nomem_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != ffha_pkg::ST_OK |-> res_addr == 32'd0)
    else $error("failed request carries an address");
  a_break_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> break_offset >= $past(break_offset)) else $error("break shrank");
`endif

endmodule

### sim/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking bench for the first-fit heap allocator: drives allocate, free,
// resize and unused-opcode requests with random idling, predicts each response
// from a behavioural copy of the chunk table, compares every field in order.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;

  localparam int NCHUNK = 64;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  status;
    logic [31:0] copy;
  } resp_t;

  class alloc_scoreboard;
    logic [31:0] start_q[NCHUNK];
    logic [32:0] len_q[NCHUNK];
    bit          free_q[NCHUNK];
    int          count;
    logic [32:0] brk;
    logic [31:0] limit;
    logic [6:0]  hdr;
    resp_t       pending[$];
    int          errors;

    function void clear();
      count = 0; brk = '0; limit = 32'd1048576; hdr = 7'd24;
      pending.delete(); errors = 0;
    endfunction

    function void set_reg(bit idx, logic [31:0] v);
      if (idx == ffha_pkg::REG_HEAP_LIMIT) limit = v;
      else hdr = v[6:0];
    endfunction

    function logic [32:0] rounded(logic [31:0] req);
      logic [32:0] r;
      r = (({1'b0, req} + 33'd7) >> 3) << 3;
      if (r < 33'd8) r = 33'd8;
      return r;
    endfunction

    function int lookup(logic [31:0] a);
      for (int i = 0; i < count; i++) if (start_q[i] == a) return i;
      return -1;
    endfunction

    function logic [31:0] grab(logic [32:0] len);
      logic [33:0] h, a, nb;
      for (int i = 0; i < count; i++)
        if (free_q[i] && len_q[i] >= len) begin
          free_q[i] = 0;
          return start_q[i];
        end
      if (count >= NCHUNK) return 32'd0;
      h = (hdr < 7'd8) ? 34'd8 : (hdr > 7'd64) ? 34'd64 : {27'd0, hdr};
      a = {1'b0, brk} + h;
      nb = a + {1'b0, len};
      if (nb > {2'b0, limit}) return 32'd0;
      start_q[count] = a[31:0]; len_q[count] = len; free_q[count] = 0;
      count++;
      brk = nb[32:0];
      return a[31:0];
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] req, logic [31:0] a);
      resp_t r;
      int idx;
      logic [32:0] len;
      r = '0;
      if (op == ffha_pkg::OP_ALLOC || (op == ffha_pkg::OP_RESIZE && a == 0)) begin
        r.addr = grab(rounded(req));
        if (r.addr == 0) r.status = ffha_pkg::ST_NOMEM;
      end else if (op == ffha_pkg::OP_FREE) begin
        if (a != 0) begin
          idx = lookup(a);
          if (idx < 0) r.status = ffha_pkg::ST_NOTFOUND;
          else free_q[idx] = 1;
        end
      end else if (op == ffha_pkg::OP_RESIZE) begin
        idx = lookup(a);
        len = rounded(req);
        if (idx < 0) r.status = ffha_pkg::ST_NOTFOUND;
        else if (len_q[idx] >= len) r.addr = a;
        else begin
          r.addr = grab(len);
          if (r.addr == 0) r.status = ffha_pkg::ST_NOMEM;
          else begin
            r.copy = len_q[idx][31:0];
            free_q[idx] = 1;
          end
        end
      end
      pending.push_back(r);
    endfunction

    task check_response(logic [71:0] d);
      resp_t e;
      if (pending.size() == 0) begin
        report("response with nothing pending", 32'd0, d[31:0]);
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.addr) report("result_address", e.addr, d[31:0]);
      if (d[33:32] !== e.status) report("status", 32'(e.status), 32'(d[33:32]));
      if (d[65:34] !== e.copy) report("copy_bytes", e.copy, d[65:34]);
    endtask

    task report(string what, logic [31:0] exp_v, logic [31:0] got);
      errors++;
      $display("mismatch %s: expected %h got %h", what, exp_v, got);
    endtask
  endclass

  logic        clk = 0, rst = 1;
  logic        s_tvalid = 0, s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid, m_tready = 0;
  logic [71:0] m_tdata;
  logic        cfg_we = 0, cfg_index = 0;
  logic [31:0] cfg_data = '0;

  alloc_scoreboard sb;
  logic [31:0] live[$];
  int    idle_pct = 14;
  bit    hold_rx = 0;
  int    quiet = 0;
  bit    done = 0;

  first_fit_heap_allocator u_top (.*);

  initial forever #10 clk = ~clk;

  task automatic send(logic [1:0] op, logic [31:0] req, logic [31:0] a);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    s_tdata = {6'b0, a, req, op};
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, req, a);
    @(negedge clk);
    s_tvalid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(bit idx, logic [31:0] v);
    drain();
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] pick_addr();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 0;
    if (k == 1 || live.size() == 0) return $urandom;
    return live[$urandom_range(live.size() - 1)];
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(19))
      0: return $urandom;
      1: return 32'hFFFF_FFF0 + $urandom_range(15);
      2: return $urandom_range(4096);
      default: return $urandom_range(200);
    endcase
  endfunction

  task automatic random_op();
    logic [1:0] op;
    logic [31:0] a, sz;
    op = 2'($urandom_range(3));
    if (op == 2'd3) op = $urandom_range(9) == 0 ? 2'd3 : ffha_pkg::OP_ALLOC;
    sz = pick_size();
    a = pick_addr();
    send(op, sz, a);
    if (op == ffha_pkg::OP_ALLOC || op == ffha_pkg::OP_RESIZE)
      if (sb.pending[$].addr != 0) live.push_back(sb.pending[$].addr);
  endtask

  always @(negedge clk) begin
    if (rst || hold_rx) m_tready <= 0;
    else if (!done && idle_pct == 0) m_tready <= 1;
    else m_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_response(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("[first_fit_heap_allocator] ERROR");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed
    send(ffha_pkg::OP_FREE, 0, 0);
    send(ffha_pkg::OP_ALLOC, 0, 0);
    send(ffha_pkg::OP_ALLOC, 1, 0);
    send(ffha_pkg::OP_ALLOC, 8, 0);
    send(ffha_pkg::OP_ALLOC, 9, 0);
    send(ffha_pkg::OP_ALLOC, 32'hFFFF_FFFF, 0);
    send(ffha_pkg::OP_ALLOC, 32'hFFFF_FFF8, 0);
    send(ffha_pkg::OP_FREE, 0, 32'd24);
    send(ffha_pkg::OP_FREE, 0, 32'd24);
    send(ffha_pkg::OP_ALLOC, 5, 0);
    send(ffha_pkg::OP_FREE, 0, 32'hFFFF_FFFF);
    send(ffha_pkg::OP_RESIZE, 0, 32'h1234_5678);
    send(ffha_pkg::OP_RESIZE, 8, 32'd24);
    send(ffha_pkg::OP_RESIZE, 100, 32'd24);
    send(ffha_pkg::OP_RESIZE, 16, 0);
    send(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ffha_pkg::OP_RESIZE, 32'hFFFF_FFFF, 32'd56);
    write_reg(ffha_pkg::REG_HEADER_BYTES, 32'd8);
    send(ffha_pkg::OP_ALLOC, 64, 0);
    write_reg(ffha_pkg::REG_HEADER_BYTES, 32'h7F);
    send(ffha_pkg::OP_ALLOC, 64, 0);
    write_reg(ffha_pkg::REG_HEADER_BYTES, 32'd0);
    send(ffha_pkg::OP_ALLOC, 64, 0);
    write_reg(ffha_pkg::REG_HEAP_LIMIT, 32'd0);
    send(ffha_pkg::OP_ALLOC, 1, 0);
    send(ffha_pkg::OP_RESIZE, 8, 32'd24);
    write_reg(ffha_pkg::REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    send(ffha_pkg::OP_ALLOC, 32'h7FFF_FFF0, 0);
    send(ffha_pkg::OP_ALLOC, 32'h7FFF_FFF0, 0);

    // random phases; no reset between phases, state carries over via table reuse
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(ffha_pkg::REG_HEAP_LIMIT, 32'hFFFF_FFFF);
        1: write_reg(ffha_pkg::REG_HEAP_LIMIT, 32'd1048576);
        2: write_reg(ffha_pkg::REG_HEADER_BYTES, 32'd64);
        3: write_reg(ffha_pkg::REG_HEADER_BYTES, 32'd24);
        4: write_reg(ffha_pkg::REG_HEAP_LIMIT, $urandom);
        5: write_reg(ffha_pkg::REG_HEADER_BYTES, $urandom_range(8, 64));
        default: ;
      endcase
      idle_pct = (ph == 3) ? 0 : 14;
      for (int n = 0; n < 300; n++) begin
        if (ph == 1 && n == 50) begin
          fork
            begin hold_rx = 1; repeat (400) @(negedge clk); hold_rx = 0; end
            for (int k = 0; k < 6; k++) random_op();
          join
        end
        if (ph == 2 && n == 100) drain();
        random_op();
      end
    end
    idle_pct = 14;

    drain();
    done = 1;
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[first_fit_heap_allocator] OK");
    else
      $display("[first_fit_heap_allocator] ERROR");
    $finish;
  end

endmodule
